### rtl/utf8_to_glyph_code_decoder_defines.svh
// Assertion macros used by the checker file of the glyph code decoder.
// Each macro expects clk_i and rst_ni to exist in the scope that uses it.
`ifndef UTF8_TO_GLYPH_CODE_DECODER_DEFINES_SVH
`define UTF8_TO_GLYPH_CODE_DECODER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define U2G_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define U2G_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/u2g_pkg.sv
`timescale 1ns / 1ps

package u2g_pkg;

  // Sizes of the table and of the queue between front and back.
  localparam int GlyphEntries = 256;
  localparam int OpFifoDepth  = 4;

  // Configuration port.
  localparam int AddrWidth = 5;
  localparam int DataWidth = 32;

  localparam logic [2:0] RegCapacity     = 3'd0;
  localparam logic [2:0] RegGlyphCount   = 3'd1;
  localparam logic [2:0] RegSpaceCode    = 3'd2;
  localparam logic [2:0] RegQuestionCode = 3'd3;
  localparam logic [2:0] RegEndCode      = 3'd4;

  localparam logic [15:0] CapacityReset     = 16'd64;
  localparam logic [8:0]  GlyphCountReset   = 9'd0;
  localparam logic [15:0] SpaceCodeReset    = 16'd1;
  localparam logic [15:0] QuestionCodeReset = 16'd2;
  localparam logic [15:0] EndCodeReset      = 16'hFFFF;

  // UTF-8 lead and continuation byte patterns.
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Tag   = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Tag   = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Tag   = 8'hF0;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContTag    = 8'h80;

  // Code points with an arithmetic mapping.
  localparam logic [20:0] SpacePoint = 21'h20;
  localparam logic [20:0] DigitFirst = 21'h30;
  localparam logic [20:0] DigitLast  = 21'h39;
  localparam logic [20:0] UpperFirst = 21'h41;
  localparam logic [20:0] UpperLast  = 21'h5A;
  localparam logic [20:0] LowerFirst = 21'h61;
  localparam logic [20:0] LowerLast  = 21'h7A;
  localparam logic [15:0] DigitBase  = 16'h0121;
  localparam logic [15:0] UpperBase  = 16'h012B;
  localparam logic [15:0] LowerBase  = 16'h0145;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_POINT,
    OP_TERM
  } op_kind_e;

  // What the same input byte still adds to the queue after this request.
  typedef enum logic [1:0] {
    FOL_NONE,
    FOL_POINT,
    FOL_TERM
  } follow_e;

  typedef struct packed {
    op_kind_e    kind;
    follow_e     follow;
    logic        bad;
    logic [20:0] point;
    logic [7:0]  index;
    logic [15:0] glyph;
  } op_t;

  typedef struct packed {
    logic [15:0] capacity;
    logic [8:0]  glyph_count;
    logic [15:0] space_code;
    logic [15:0] question_code;
    logic [15:0] end_code;
  } cfg_t;

  typedef struct packed {
    logic [20:0] point;
    logic [15:0] glyph;
  } glyph_entry_t;

  typedef struct packed {
    logic [15:0] glyph;
    logic        was_unmapped;
    logic        end_of_string;
    logic        truncated;
    logic [15:0] written_total;
    logic [15:0] unmapped_total;
    logic        last;
  } result_t;

endpackage

### rtl/u2g_channels.sv
`timescale 1ns / 1ps

// Input channel: stream bytes and glyph table writes.
interface u2g_item_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  data_byte;
  logic [7:0]  entry_index;
  logic [20:0] entry_code_point;
  logic [15:0] entry_glyph;

  modport source (
    output valid, req_type, data_byte, entry_index, entry_code_point, entry_glyph,
    input  ready
  );
  modport sink (
    input  valid, req_type, data_byte, entry_index, entry_code_point, entry_glyph,
    output ready
  );
endinterface

// Output channel: glyph code records and terminator records.
interface u2g_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] glyph;
  logic        was_unmapped;
  logic        end_of_string;
  logic        truncated;
  logic [15:0] written_total;
  logic [15:0] unmapped_total;
  logic        last;

  modport source (
    output valid, glyph, was_unmapped, end_of_string, truncated, written_total,
           unmapped_total, last,
    input  ready
  );
  modport sink (
    input  valid, glyph, was_unmapped, end_of_string, truncated, written_total,
           unmapped_total, last,
    output ready
  );
endinterface

### rtl/u2g_front.sv
`timescale 1ns / 1ps

// Front end: accepts requests, tracks UTF-8 sequences and queues work
// requests for the back end (table writes, code points, terminators).
module u2g_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            req_type_i,
  input  logic [7:0]      data_byte_i,
  input  logic [7:0]      entry_index_i,
  input  logic [20:0]     entry_code_point_i,
  input  logic [15:0]     entry_glyph_i,
  output logic            push_valid_o,
  output u2g_pkg::op_t    push_op_o,
  input  logic            fifo_full_i
);

  typedef struct packed {
    logic        emit;
    logic        bad;
    logic [20:0] point;
    logic [1:0]  pend;
    logic [20:0] part;
  } lead_t;

  // Classify a byte that starts a new sequence.
  function automatic lead_t decode_lead(logic [7:0] b);
    lead_t r;
    r = '0;
    if (b < u2g_pkg::AsciiLimit) begin
      r.emit  = 1'b1;
      r.point = {13'd0, b};
    end else if ((b & u2g_pkg::Lead2Mask) == u2g_pkg::Lead2Tag) begin
      r.pend = 2'd1;
      r.part = {16'd0, b[4:0]};
    end else if ((b & u2g_pkg::Lead3Mask) == u2g_pkg::Lead3Tag) begin
      r.pend = 2'd2;
      r.part = {17'd0, b[3:0]};
    end else if ((b & u2g_pkg::Lead4Mask) == u2g_pkg::Lead4Tag) begin
      r.pend = 2'd3;
      r.part = {18'd0, b[2:0]};
    end else begin
      r.emit = 1'b1;
      r.bad  = 1'b1;
    end
    return r;
  endfunction

  function automatic u2g_pkg::op_t point_op(logic [20:0] point, logic bad,
                                            u2g_pkg::follow_e follow);
    u2g_pkg::op_t o;
    o        = '0;
    o.kind   = u2g_pkg::OP_POINT;
    o.follow = follow;
    o.bad    = bad;
    o.point  = point;
    return o;
  endfunction

  logic [1:0]   pend_q, pend_d;
  logic [20:0]  part_q, part_d;
  logic         hold_valid_q;
  u2g_pkg::op_t hold_op_q;

  u2g_pkg::op_t op0, op1;
  logic         op0_valid, op1_valid;
  lead_t        lead;
  logic [20:0]  part_next;
  logic         accept;

  assign in_ready_o = !hold_valid_q && !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign lead       = decode_lead(data_byte_i);
  assign part_next  = {part_q[14:0], data_byte_i[5:0]};

  // Decode the offered byte into at most two queue requests.
  always_comb begin
    op0       = '0;
    op1       = '0;
    op0_valid = 1'b0;
    op1_valid = 1'b0;
    pend_d    = pend_q;
    part_d    = part_q;
    if (req_type_i) begin
      op0.kind  = u2g_pkg::OP_WRITE;
      op0.index = entry_index_i;
      op0.point = entry_code_point_i;
      op0.glyph = entry_glyph_i;
      op0_valid = 1'b1;
    end else begin
      if (pend_q != 2'd0) begin
        if ((data_byte_i & u2g_pkg::ContMask) == u2g_pkg::ContTag) begin
          pend_d = pend_q - 2'd1;
          part_d = part_next;
          if (pend_q == 2'd1) begin
            op0       = point_op(part_next, 1'b0, u2g_pkg::FOL_NONE);
            op0_valid = 1'b1;
          end
        end else begin
          // The sequence is broken: one bad point, then the byte starts over.
          pend_d    = 2'd0;
          op0_valid = 1'b1;
          if (data_byte_i == 8'd0) begin
            op0       = point_op('0, 1'b1, u2g_pkg::FOL_TERM);
            op1.kind  = u2g_pkg::OP_TERM;
            op1_valid = 1'b1;
          end else if (lead.emit) begin
            op0       = point_op('0, 1'b1, u2g_pkg::FOL_POINT);
            op1       = point_op(lead.point, lead.bad, u2g_pkg::FOL_NONE);
            op1_valid = 1'b1;
          end else begin
            op0    = point_op('0, 1'b1, u2g_pkg::FOL_NONE);
            pend_d = lead.pend;
            part_d = lead.part;
          end
        end
      end else if (data_byte_i != 8'd0) begin
        if (lead.emit) begin
          op0       = point_op(lead.point, lead.bad, u2g_pkg::FOL_NONE);
          op0_valid = 1'b1;
        end else begin
          pend_d = lead.pend;
          part_d = lead.part;
        end
      end else begin
        op0.kind  = u2g_pkg::OP_TERM;
        op0_valid = 1'b1;
      end
      // The terminator clears the sequence state for the next string.
      if (data_byte_i == 8'd0) begin
        pend_d = 2'd0;
        part_d = '0;
      end
    end
  end

  // A second request waits in the holding register while input is stalled.
  assign push_valid_o = hold_valid_q ? !fifo_full_i : (accept && op0_valid);
  assign push_op_o    = hold_valid_q ? hold_op_q : op0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= 2'd0;
      part_q       <= '0;
      hold_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pend_q       <= pend_d;
        part_q       <= part_d;
        hold_valid_q <= op1_valid;
      end else if (hold_valid_q && !fifo_full_i) begin
        hold_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_op_q <= op1;
    end
  end

endmodule

### rtl/u2g_op_fifo.sv
`timescale 1ns / 1ps

// Short request queue between the front end and the back end.
module u2g_op_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  u2g_pkg::op_t push_op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output u2g_pkg::op_t pop_op_o
);

  localparam int Depth = u2g_pkg::OpFifoDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  u2g_pkg::op_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic do_push, do_pop;

  assign full_o   = (count_q == CntW'(Depth));
  assign valid_o  = (count_q != '0);
  assign pop_op_o = slot_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && valid_o;

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

### rtl/u2g_back.sv
`timescale 1ns / 1ps

// Back end: holds the glyph table, maps code points to engine codes,
// keeps the per-string counters and drives the result register.
module u2g_back #(
  parameter int GLYPH_ENTRIES = u2g_pkg::GlyphEntries
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  u2g_pkg::cfg_t    cfg_i,
  input  logic             op_valid_i,
  input  u2g_pkg::op_t     op_i,
  output logic             op_pop_o,
  output logic             res_valid_o,
  output u2g_pkg::result_t res_o,
  input  logic             res_ready_i
);

  localparam int AW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int IW = $clog2(GLYPH_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e                state_q;
  logic [15:0]           written_q, unmapped_q;
  logic                  cut_q;
  logic [20:0]           point_q;
  u2g_pkg::follow_e      follow_q;
  logic                  term_q;
  logic [15:0]           code_q;
  logic                  un_q;
  logic [IW-1:0]         rd_idx_q;
  logic                  rd_valid_q;
  u2g_pkg::glyph_entry_t rdata_q;
  logic                  out_valid_q;
  u2g_pkg::result_t      out_q;

  u2g_pkg::glyph_entry_t table_mem [GLYPH_ENTRIES];

  logic [15:0]   cap_eff, cap_m1;
  logic [IW-1:0] search_n;
  logic          arith_hit;
  logic [15:0]   arith_code;
  logic          write_ok;
  logic          can_emit;
  logic          last_flag;

  assign op_pop_o    = (state_q == S_IDLE) && op_valid_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign can_emit    = !out_valid_q || res_ready_i;

  // Limits taken from the configuration.
  assign cap_eff  = (cfg_i.capacity == 16'd0) ? 16'd1 : cfg_i.capacity;
  assign cap_m1   = cap_eff - 16'd1;
  assign search_n = (int'(cfg_i.glyph_count) >= GLYPH_ENTRIES) ? IW'(GLYPH_ENTRIES)
                                                               : IW'(cfg_i.glyph_count);
  assign write_ok = (int'(op_i.index) < GLYPH_ENTRIES);

  // Space, digits and letters map without the table.
  always_comb begin
    arith_hit  = 1'b1;
    arith_code = '0;
    if (op_i.point == u2g_pkg::SpacePoint) begin
      arith_code = cfg_i.space_code;
    end else if (op_i.point inside {[u2g_pkg::DigitFirst:u2g_pkg::DigitLast]}) begin
      arith_code = u2g_pkg::DigitBase + 16'(op_i.point - u2g_pkg::DigitFirst);
    end else if (op_i.point inside {[u2g_pkg::UpperFirst:u2g_pkg::UpperLast]}) begin
      arith_code = u2g_pkg::UpperBase + 16'(op_i.point - u2g_pkg::UpperFirst);
    end else if (op_i.point inside {[u2g_pkg::LowerFirst:u2g_pkg::LowerLast]}) begin
      arith_code = u2g_pkg::LowerBase + 16'(op_i.point - u2g_pkg::LowerFirst);
    end else begin
      arith_hit = 1'b0;
    end
  end

  // A code is the last result of its byte unless a follower will also emit.
  always_comb begin
    case (follow_q)
      u2g_pkg::FOL_NONE:  last_flag = 1'b1;
      u2g_pkg::FOL_TERM:  last_flag = 1'b0;
      u2g_pkg::FOL_POINT: last_flag = ({1'b0, written_q} + 17'd1) >= {1'b0, cap_m1};
      default:            last_flag = 1'b1;
    endcase
  end

  // Glyph table: one write port for table requests, one read port for the scan.
  always_ff @(posedge clk_i) begin
    if (op_pop_o && op_i.kind == u2g_pkg::OP_WRITE && write_ok) begin
      table_mem[AW'(op_i.index)] <= {op_i.point, op_i.glyph};
    end
    if (state_q == S_SCAN) begin
      rdata_q <= table_mem[rd_idx_q[AW-1:0]];
    end
  end

  // Sequencer with counters and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      written_q   <= '0;
      unmapped_q  <= '0;
      cut_q       <= 1'b0;
      point_q     <= '0;
      follow_q    <= u2g_pkg::FOL_NONE;
      term_q      <= 1'b0;
      code_q      <= '0;
      un_q        <= 1'b0;
      rd_idx_q    <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (op_valid_i) begin
            point_q  <= op_i.point;
            follow_q <= op_i.follow;
            term_q   <= 1'b0;
            case (op_i.kind)
              u2g_pkg::OP_WRITE: begin
                state_q <= S_IDLE;
              end
              u2g_pkg::OP_TERM: begin
                term_q   <= 1'b1;
                follow_q <= u2g_pkg::FOL_NONE;
                state_q  <= S_EMIT;
              end
              u2g_pkg::OP_POINT: begin
                if (cut_q) begin
                  state_q <= S_IDLE;
                end else if (written_q >= cap_m1) begin
                  cut_q <= 1'b1;
                end else if (op_i.bad || (arith_hit && arith_code == 16'd0)) begin
                  code_q  <= cfg_i.question_code;
                  un_q    <= 1'b1;
                  state_q <= S_EMIT;
                end else if (arith_hit) begin
                  code_q  <= arith_code;
                  un_q    <= 1'b0;
                  state_q <= S_EMIT;
                end else if (search_n == '0) begin
                  code_q  <= cfg_i.question_code;
                  un_q    <= 1'b1;
                  state_q <= S_EMIT;
                end else begin
                  rd_idx_q   <= '0;
                  rd_valid_q <= 1'b0;
                  state_q    <= S_SCAN;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          // One entry read per cycle; the compare runs one entry behind.
          if (rd_valid_q && rdata_q.point == point_q) begin
            code_q     <= (rdata_q.glyph == 16'd0) ? cfg_i.question_code : rdata_q.glyph;
            un_q       <= (rdata_q.glyph == 16'd0);
            rd_valid_q <= 1'b0;
            state_q    <= S_EMIT;
          end else if (rd_valid_q && rd_idx_q == search_n) begin
            code_q     <= cfg_i.question_code;
            un_q       <= 1'b1;
            rd_valid_q <= 1'b0;
            state_q    <= S_EMIT;
          end else begin
            rd_idx_q   <= rd_idx_q + IW'(1);
            rd_valid_q <= 1'b1;
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            if (term_q) begin
              out_q.glyph          <= cfg_i.end_code;
              out_q.was_unmapped   <= 1'b0;
              out_q.end_of_string  <= 1'b1;
              out_q.truncated      <= cut_q;
              out_q.written_total  <= written_q;
              out_q.unmapped_total <= unmapped_q;
              out_q.last           <= 1'b1;
              written_q            <= '0;
              unmapped_q           <= '0;
              cut_q                <= 1'b0;
            end else begin
              out_q.glyph          <= code_q;
              out_q.was_unmapped   <= un_q;
              out_q.end_of_string  <= 1'b0;
              out_q.truncated      <= 1'b0;
              out_q.written_total  <= '0;
              out_q.unmapped_total <= '0;
              out_q.last           <= last_flag;
              written_q            <= written_q + 16'd1;
              unmapped_q           <= unmapped_q + {15'd0, un_q};
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/utf8_to_glyph_code_decoder.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake        Carries
// item_i     in         valid / ready    stream byte or glyph table write
// result_o   out        valid / ready    glyph code record or terminator record
// apb        in/out     psel / penable   configuration registers, pready tied high
//
// The front end takes one request per cycle while the queue has room, and holds
// its input while the second request of a byte waits; a four-deep queue separates
// it from the back end. The back end handles table writes, mapped or bad codes
// and table lookups over n <= glyph_count entries, one entry per cycle from the
// single read port of the table memory.
// Reset clears control state and counters; the table stays undefined until written.
// A stalled result holds the back end at its next record, and the input only
// once the queue is full.
module utf8_to_glyph_code_decoder #(
  parameter int GLYPH_ENTRIES = u2g_pkg::GlyphEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  u2g_item_if.sink                      item_i,
  u2g_result_if.source                  result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [u2g_pkg::AddrWidth-1:0] paddr,
  input  logic [u2g_pkg::DataWidth-1:0] pwdata,
  output logic [u2g_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  u2g_pkg::cfg_t    cfg_q;
  logic             push_valid, fifo_full, op_valid, op_pop;
  u2g_pkg::op_t     push_op, pop_op;
  u2g_pkg::result_t res;
  logic             res_valid;
  logic [2:0]       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[u2g_pkg::AddrWidth-1:2];

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity      <= u2g_pkg::CapacityReset;
      cfg_q.glyph_count   <= u2g_pkg::GlyphCountReset;
      cfg_q.space_code    <= u2g_pkg::SpaceCodeReset;
      cfg_q.question_code <= u2g_pkg::QuestionCodeReset;
      cfg_q.end_code      <= u2g_pkg::EndCodeReset;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        u2g_pkg::RegCapacity:     cfg_q.capacity      <= pwdata[15:0];
        u2g_pkg::RegGlyphCount:   cfg_q.glyph_count   <= pwdata[8:0];
        u2g_pkg::RegSpaceCode:    cfg_q.space_code    <= pwdata[15:0];
        u2g_pkg::RegQuestionCode: cfg_q.question_code <= pwdata[15:0];
        u2g_pkg::RegEndCode:      cfg_q.end_code      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    case (reg_sel)
      u2g_pkg::RegCapacity:     prdata = {16'd0, cfg_q.capacity};
      u2g_pkg::RegGlyphCount:   prdata = {23'd0, cfg_q.glyph_count};
      u2g_pkg::RegSpaceCode:    prdata = {16'd0, cfg_q.space_code};
      u2g_pkg::RegQuestionCode: prdata = {16'd0, cfg_q.question_code};
      u2g_pkg::RegEndCode:      prdata = {16'd0, cfg_q.end_code};
      default:                  prdata = '0;
    endcase
  end

  u2g_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (item_i.valid),
    .in_ready_o         (item_i.ready),
    .req_type_i         (item_i.req_type),
    .data_byte_i        (item_i.data_byte),
    .entry_index_i      (item_i.entry_index),
    .entry_code_point_i (item_i.entry_code_point),
    .entry_glyph_i      (item_i.entry_glyph),
    .push_valid_o       (push_valid),
    .push_op_o          (push_op),
    .fifo_full_i        (fifo_full)
  );

  u2g_op_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_valid),
    .push_op_i (push_op),
    .full_o    (fifo_full),
    .pop_i     (op_pop),
    .valid_o   (op_valid),
    .pop_op_o  (pop_op)
  );

  u2g_back #(
    .GLYPH_ENTRIES (GLYPH_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (op_valid),
    .op_i        (pop_op),
    .op_pop_o    (op_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (result_o.ready)
  );

  // Result channel.
  assign result_o.valid          = res_valid;
  assign result_o.glyph          = res.glyph;
  assign result_o.was_unmapped   = res.was_unmapped;
  assign result_o.end_of_string  = res.end_of_string;
  assign result_o.truncated      = res.truncated;
  assign result_o.written_total  = res.written_total;
  assign result_o.unmapped_total = res.unmapped_total;
  assign result_o.last           = res.last;

endmodule

### rtl/u2g_checker.sv
`timescale 1ns / 1ps
`include "utf8_to_glyph_code_decoder_defines.svh"

// Port-level checks on the result channel of the decoder.
module u2g_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [15:0] glyph_i,
  input logic        was_unmapped_i,
  input logic        end_of_string_i,
  input logic        truncated_i,
  input logic [15:0] written_total_i,
  input logic [15:0] unmapped_total_i,
  input logic        last_i
);

  logic        term_rec;
  logic        code_rec;
  logic        totals_zero;
  logic        stalled;
  logic [52:0] held_fields;

  assign term_rec    = res_valid_i && end_of_string_i;
  assign code_rec    = res_valid_i && !end_of_string_i;
  assign totals_zero = !truncated_i && written_total_i == 16'd0 && unmapped_total_i == 16'd0;
  assign stalled     = res_valid_i && !res_ready_i;
  assign held_fields = {glyph_i, was_unmapped_i, end_of_string_i, truncated_i,
                        written_total_i, unmapped_total_i, last_i};

  // A terminator record always closes its byte and is never a replacement.
  `U2G_ASSERT_NOW(a_term_last, term_rec, last_i && !was_unmapped_i, "bad terminator record")

  // Code records carry no totals.
  `U2G_ASSERT_NOW(a_code_no_totals, code_rec, totals_zero, "code record carries totals")

  // Replaced codes are a subset of written codes.
  `U2G_ASSERT_NOW(a_totals_order, term_rec, unmapped_total_i <= written_total_i, "totals out of order")

  // A stalled result keeps its contents.
  `U2G_ASSERT_NEXT(a_hold, stalled, res_valid_i && $stable(held_fields), "stalled result changed")

endmodule

bind utf8_to_glyph_code_decoder u2g_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (result_o.valid),
  .res_ready_i      (result_o.ready),
  .glyph_i          (result_o.glyph),
  .was_unmapped_i   (result_o.was_unmapped),
  .end_of_string_i  (result_o.end_of_string),
  .truncated_i      (result_o.truncated),
  .written_total_i  (result_o.written_total),
  .unmapped_total_i (result_o.unmapped_total),
  .last_i           (result_o.last)
);

### tb/utf8_to_glyph_code_decoder_tb.sv
`timescale 1ns / 1ps

module utf8_to_glyph_code_decoder_tb;

  // Cycles to wait after the last record before touching registers or ending:
  // a full queue of worst-case table lookups.
  localparam int DrainCycles = u2g_pkg::OpFifoDepth * (u2g_pkg::GlyphEntries + 3) + 64;
  localparam int MaxReports = 10;
  localparam int RandomItems = 600;
  localparam logic ReqStream = 1'b0;
  localparam logic ReqTableWrite = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [u2g_pkg::AddrWidth-1:0] paddr;
  logic [u2g_pkg::DataWidth-1:0] pwdata;
  logic [u2g_pkg::DataWidth-1:0] prdata;
  logic pready;

  u2g_item_if item_ch ();
  u2g_result_if result_ch ();

  utf8_to_glyph_code_decoder #(
    .GLYPH_ENTRIES(u2g_pkg::GlyphEntries)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .item_i(item_ch),
    .result_o(result_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk_i = ~clk_i;

  // Decoder state as the testbench sees it.
  u2g_pkg::cfg_t cfg;
  logic [1:0] pend_bytes;
  logic [20:0] partial_cp;
  logic [15:0] written_cnt;
  logic [15:0] unmapped_cnt;
  logic cut_flag;
  logic [20:0] table_cp [u2g_pkg::GlyphEntries];
  logic [15:0] table_code [u2g_pkg::GlyphEntries];

  u2g_pkg::result_t glyph_records_due[$];
  int mismatches = 0;
  int items_sent = 0;
  bit idling_on = 1'b1;

  // Arithmetic ranges first, then a first-match search of the glyph table.
  function automatic logic [15:0] map_code_point(input logic [20:0] cp);
    int limit;
    limit = (cfg.glyph_count < u2g_pkg::GlyphEntries) ? int'(cfg.glyph_count)
                                                      : u2g_pkg::GlyphEntries;
    if (cp == u2g_pkg::SpacePoint) return cfg.space_code;
    if (cp >= u2g_pkg::DigitFirst && cp <= u2g_pkg::DigitLast)
      return u2g_pkg::DigitBase + 16'(cp - u2g_pkg::DigitFirst);
    if (cp >= u2g_pkg::UpperFirst && cp <= u2g_pkg::UpperLast)
      return u2g_pkg::UpperBase + 16'(cp - u2g_pkg::UpperFirst);
    if (cp >= u2g_pkg::LowerFirst && cp <= u2g_pkg::LowerLast)
      return u2g_pkg::LowerBase + 16'(cp - u2g_pkg::LowerFirst);
    for (int i = 0; i < limit; i++) begin
      if (table_cp[i] == cp) return table_code[i];
    end
    return '0;
  endfunction

  // A completed or bad code point: respects capacity, replaces zero codes.
  task automatic emit_code_point(input logic [20:0] cp, input logic bad);
    int cap;
    logic [15:0] code;
    u2g_pkg::result_t rec;
    cap = (cfg.capacity == '0) ? 1 : int'(cfg.capacity);
    if (cut_flag) return;
    if (int'(written_cnt) >= cap - 1) begin
      cut_flag = 1'b1;
      return;
    end
    code = bad ? 16'h0 : map_code_point(cp);
    rec = '0;
    if (code == 16'h0) begin
      code = cfg.question_code;
      rec.was_unmapped = 1'b1;
      unmapped_cnt++;
    end
    written_cnt++;
    rec.glyph = code;
    glyph_records_due.push_back(rec);
  endtask

  // A byte seen where a new sequence may begin.
  task automatic start_sequence(input logic [7:0] b);
    if (b < u2g_pkg::AsciiLimit) begin
      emit_code_point(21'(b), 1'b0);
    end else if ((b & u2g_pkg::Lead2Mask) == u2g_pkg::Lead2Tag) begin
      partial_cp = 21'(b & 8'h1F);
      pend_bytes = 2'd1;
    end else if ((b & u2g_pkg::Lead3Mask) == u2g_pkg::Lead3Tag) begin
      partial_cp = 21'(b & 8'h0F);
      pend_bytes = 2'd2;
    end else if ((b & u2g_pkg::Lead4Mask) == u2g_pkg::Lead4Tag) begin
      partial_cp = 21'(b & 8'h07);
      pend_bytes = 2'd3;
    end else begin
      emit_code_point('0, 1'b1);
    end
  endtask

  // Works out the records that one accepted request causes.
  task automatic decode_request(input logic rtype, input logic [7:0] b,
                                input logic [7:0] idx, input logic [20:0] cp,
                                input logic [15:0] g);
    int start_count;
    u2g_pkg::result_t term;
    start_count = glyph_records_due.size();
    if (rtype == ReqTableWrite) begin
      table_cp[idx] = cp;
      table_code[idx] = g;
      return;
    end
    if (!cut_flag) begin
      if (pend_bytes != 2'd0) begin
        if ((b & u2g_pkg::ContMask) == u2g_pkg::ContTag) begin
          partial_cp = {partial_cp[14:0], b[5:0]};
          pend_bytes--;
          if (pend_bytes == 2'd0) emit_code_point(partial_cp, 1'b0);
        end else begin
          // Broken sequence: one bad point, then the byte starts over.
          pend_bytes = 2'd0;
          emit_code_point('0, 1'b1);
          if (b != 8'h00 && !cut_flag) start_sequence(b);
        end
      end else if (b != 8'h00) begin
        start_sequence(b);
      end
    end
    if (b == 8'h00) begin
      term = '0;
      term.glyph = cfg.end_code;
      term.end_of_string = 1'b1;
      term.truncated = cut_flag;
      term.written_total = written_cnt;
      term.unmapped_total = unmapped_cnt;
      glyph_records_due.push_back(term);
      pend_bytes = '0;
      partial_cp = '0;
      written_cnt = '0;
      unmapped_cnt = '0;
      cut_flag = 1'b0;
    end
    if (glyph_records_due.size() > start_count) glyph_records_due[$].last = 1'b1;
  endtask

  // Drives one request from a falling edge and holds it until accepted.
  task automatic send_request(input logic rtype, input logic [7:0] b,
                              input logic [7:0] idx, input logic [20:0] cp,
                              input logic [15:0] g);
    if (idling_on && $urandom_range(0, 99) < 12) begin
      item_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.req_type <= rtype;
    item_ch.data_byte <= b;
    item_ch.entry_index <= idx;
    item_ch.entry_code_point <= cp;
    item_ch.entry_glyph <= g;
    do @(posedge clk_i); while (!item_ch.ready);
    decode_request(rtype, b, idx, cp, g);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stream bytes carry random table fields so that those bits toggle too.
  task automatic send_byte(input logic [7:0] b);
    send_request(ReqStream, b, 8'($urandom), 21'($urandom), 16'($urandom));
  endtask

  task automatic send_table_write(input logic [7:0] idx, input logic [20:0] cp,
                                  input logic [15:0] g);
    send_request(ReqTableWrite, 8'($urandom), idx, cp, g);
  endtask

  function automatic int utf8_length(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Sends the first keep bytes of a len-byte encoding of cp. A zero point with
  // len one is sent whole in overlong form so that it does not end the string.
  task automatic send_code_point(input logic [20:0] cp, input int len, input int keep);
    logic [7:0] seq [4];
    int n;
    int cnt;
    n = (len == 1 && cp == '0) ? 2 : len;
    cnt = (n != len) ? n : keep;
    case (n)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < cnt && i < n; i++) send_byte(seq[i]);
  endtask

  // Waits until every record is in and the back end has had time to finish
  // requests that produce nothing.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (glyph_records_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // One register write: setup cycle, access cycle, then release.
  task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (reg_idx)
      u2g_pkg::RegCapacity: cfg.capacity = value[15:0];
      u2g_pkg::RegGlyphCount: cfg.glyph_count = value[8:0];
      u2g_pkg::RegSpaceCode: cfg.space_code = value[15:0];
      u2g_pkg::RegQuestionCode: cfg.question_code = value[15:0];
      u2g_pkg::RegEndCode: cfg.end_code = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic configure(input u2g_pkg::cfg_t c);
    wait_idle();
    apb_write(u2g_pkg::RegCapacity, 32'(c.capacity));
    apb_write(u2g_pkg::RegGlyphCount, 32'(c.glyph_count));
    apb_write(u2g_pkg::RegSpaceCode, 32'(c.space_code));
    apb_write(u2g_pkg::RegQuestionCode, 32'(c.question_code));
    apb_write(u2g_pkg::RegEndCode, 32'(c.end_code));
  endtask

  // Reset settings: range ends of the arithmetic mappings, an unmapped ASCII
  // point, a stray continuation, a bad lead, and broken sequences, one of
  // them broken by the terminator.
  task automatic test_ascii_and_malformed();
    logic [7:0] bytes [$];
    bytes = '{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h20, 8'h7F,
              8'h80, 8'hFF, 8'hC3, 8'h41, 8'h00, 8'hE2, 8'h82, 8'h00};
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // Fills the whole table, with a duplicate point and a zero glyph, and
  // looks up through all of it.
  task automatic test_glyph_table();
    logic [20:0] cp;
    logic [15:0] g;
    u2g_pkg::cfg_t c;
    for (int i = 0; i < u2g_pkg::GlyphEntries; i++) begin
      cp = (i == 7) ? table_cp[3] : 21'($urandom);
      g = (i == 5) ? 16'h0000 : 16'($urandom);
      send_table_write(8'(i), cp, g);
    end
    c = cfg;
    c.glyph_count = 9'(u2g_pkg::GlyphEntries);
    configure(c);
    send_code_point(table_cp[255], 4, 4);
    send_code_point(table_cp[7], utf8_length(table_cp[7]), 4);
    send_code_point(table_cp[5], utf8_length(table_cp[5]), 4);
    send_byte(8'h7E);
    send_byte(8'h00);
  endtask

  // Truncation at a small capacity, capacity one and zero, the largest
  // capacity, and a glyph count beyond the table size.
  task automatic test_capacity_limits();
    u2g_pkg::cfg_t c;
    c = cfg;
    c.capacity = 16'd3;
    configure(c);
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte(8'h43);
    send_byte(8'h44);
    send_byte(8'h00);
    c.capacity = 16'd1;
    configure(c);
    send_byte(8'h41);
    send_byte(8'h00);
    c.capacity = 16'd0;
    configure(c);
    send_byte(8'h41);
    send_byte(8'h00);
    c.capacity = 16'hFFFF;
    c.glyph_count = 9'h1FF;
    configure(c);
    send_code_point(table_cp[200], utf8_length(table_cp[200]), 4);
    send_byte(8'h00);
  endtask

  // Code registers at their extremes, a zero space code among them.
  task automatic test_code_registers();
    u2g_pkg::cfg_t c;
    c = cfg;
    c.space_code = 16'h0000;
    c.question_code = 16'hFFFF;
    c.end_code = 16'h0000;
    configure(c);
    send_byte(8'h20);
    send_byte(8'h00);
    c.space_code = 16'hFFFF;
    c.question_code = 16'h0000;
    c.end_code = 16'hFFFF;
    configure(c);
    send_byte(8'h20);
    send_byte(8'h7F);
    send_byte(8'h00);
  endtask

  // Mostly well-formed points with random content, some noise and broken
  // sequences, and the occasional table write in between.
  task automatic send_random_string(input int n_points);
    int kind;
    int sub;
    int len;
    int limit;
    logic [20:0] cp;
    limit = (cfg.glyph_count < u2g_pkg::GlyphEntries) ? int'(cfg.glyph_count)
                                                      : u2g_pkg::GlyphEntries;
    for (int k = 0; k < n_points; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        send_table_write(8'($urandom), 21'($urandom),
                         ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom));
      end else if (kind < 8) begin
        send_byte(8'h80 | 8'($urandom_range(0, 63)));
      end else if (kind < 11) begin
        send_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
        sub = $urandom_range(0, 99);
        if (sub < 40 && limit > 0) cp = table_cp[$urandom_range(0, limit - 1)];
        else if (sub < 70) cp = 21'($urandom_range(1, 8'h7F));
        else cp = 21'($urandom) >> $urandom_range(0, 14);
        len = utf8_length(cp);
        if ($urandom_range(0, 9) == 0) len = $urandom_range(len, 4);
        if (kind < 17 && len > 1) send_code_point(cp, len, $urandom_range(1, len - 1));
        else send_code_point(cp, len, len);
      end
    end
    send_byte(8'h00);
  endtask

  // Phases of random settings; the first runs with no idling on either side.
  task automatic test_random_strings();
    int start_count;
    int phase;
    int sel;
    u2g_pkg::cfg_t c;
    start_count = items_sent;
    phase = 0;
    while (items_sent - start_count < RandomItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) c.capacity = 16'($urandom_range(1, 24));
      else if (sel < 85) c.capacity = 16'($urandom_range(25, 400));
      else if (sel < 93) c.capacity = 16'd1;
      else c.capacity = 16'hFFFF;
      sel = $urandom_range(0, 99);
      if (sel < 70) c.glyph_count = 9'($urandom_range(0, 16));
      else if (sel < 90) c.glyph_count = 9'($urandom_range(17, 64));
      else c.glyph_count = 9'(u2g_pkg::GlyphEntries);
      c.space_code = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
      c.question_code = ($urandom_range(0, 19) == 0) ? 16'h0000 : 16'($urandom);
      c.end_code = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
      configure(c);
      idling_on = (phase != 0);
      repeat ($urandom_range(4, 10)) send_random_string($urandom_range(0, 30));
      phase++;
    end
    idling_on = 1'b1;
  endtask

  // The result side stalls at random while idling is on.
  always @(negedge clk_i) begin
    result_ch.ready <= !idling_on || ($urandom_range(0, 99) >= 12);
  end

  // Each accepted record is compared with the oldest one due.
  always @(posedge clk_i) begin
    u2g_pkg::result_t got;
    u2g_pkg::result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got.glyph = result_ch.glyph;
      got.was_unmapped = result_ch.was_unmapped;
      got.end_of_string = result_ch.end_of_string;
      got.truncated = result_ch.truncated;
      got.written_total = result_ch.written_total;
      got.unmapped_total = result_ch.unmapped_total;
      got.last = result_ch.last;
      if (glyph_records_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected record: glyph %h eos %b", got.glyph, got.end_of_string);
      end else begin
        want = glyph_records_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("record mismatch: expected glyph %h un %b eos %b tr %b wt %0d ut %0d last %b",
                     want.glyph, want.was_unmapped, want.end_of_string, want.truncated,
                     want.written_total, want.unmapped_total, want.last);
            $display("                   actual glyph %h un %b eos %b tr %b wt %0d ut %0d last %b",
                     got.glyph, got.was_unmapped, got.end_of_string, got.truncated,
                     got.written_total, got.unmapped_total, got.last);
          end
        end
      end
    end
  end

  // Guard against a hang.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.req_type = ReqStream;
    item_ch.data_byte = '0;
    item_ch.entry_index = '0;
    item_ch.entry_code_point = '0;
    item_ch.entry_glyph = '0;
    result_ch.ready = 1'b0;
    cfg.capacity = u2g_pkg::CapacityReset;
    cfg.glyph_count = u2g_pkg::GlyphCountReset;
    cfg.space_code = u2g_pkg::SpaceCodeReset;
    cfg.question_code = u2g_pkg::QuestionCodeReset;
    cfg.end_code = u2g_pkg::EndCodeReset;
    pend_bytes = '0;
    partial_cp = '0;
    written_cnt = '0;
    unmapped_cnt = '0;
    cut_flag = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_ascii_and_malformed();
    test_glyph_table();
    test_capacity_limits();
    test_code_registers();
    test_random_strings();

    wait_idle();
    if (mismatches == 0 && glyph_records_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
